>>> rtl/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package flptw_pkg;

  localparam int INDEX_BITS     = 9;
  localparam int PHYS_ADDR_BITS = 48;
  localparam int PAGE_SHIFT     = 12;
  localparam int ADDR_W         = 48;
  localparam int VPN_W          = 4 * INDEX_BITS;
  localparam int BASE_W         = ADDR_W - PAGE_SHIFT;

  // Physical address bits PHYS_ADDR_BITS-1 down to 12, cut to the 48-bit fields
  localparam logic [ADDR_W-1:0] PA_MASK =
    ((ADDR_W'(1) << PHYS_ADDR_BITS) - ADDR_W'(1)) & ~ADDR_W'(12'hFFF);

  localparam logic ACTION_START    = 1'b0;
  localparam logic ACTION_RESPONSE = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] STATUS_MAPPED  = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOT = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef struct packed {
    logic        action;
    logic [63:0] vaddr;
    logic [63:0] read_entry;
  } item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] read_addr;
    logic [1:0]        status;
    logic [1:0]        fault_level;
    logic [ADDR_W-1:0] phys_page;
    logic              leaf_is_table;
    logic [1:0]        leaf_access_perm;
    logic [1:0]        leaf_shareability;
    logic              leaf_access_flag;
    logic              leaf_priv_xn;
    logic              leaf_user_xn;
    logic [2:0]        leaf_attr_index;
  } result_t;

  typedef struct packed {
    logic              busy;
    logic [1:0]        level;
    logic [VPN_W-1:0]  page_number;
    logic [BASE_W-1:0] table_base;
  } walk_state_t;

endpackage

>>> rtl/flptw_step.sv
// ----------------------------------------------------------------------------
// flptw_step
// One walk step: next walk state and the result caused by one transaction.
// ----------------------------------------------------------------------------
module flptw_step (
  input  flptw_pkg::walk_state_t         walk,
  input  flptw_pkg::item_t               item,
  input  logic [flptw_pkg::ADDR_W-1:0]   root_table_base,
  output flptw_pkg::walk_state_t         walk_next,
  output logic                           fire,
  output flptw_pkg::result_t             result
);
  import flptw_pkg::*;

  logic [ADDR_W-1:0]     root;
  logic [ADDR_W-1:0]     entry_pa;
  logic [INDEX_BITS-1:0] idx;

  assign root     = root_table_base & PA_MASK;
  assign entry_pa = item.read_entry[ADDR_W-1:0] & PA_MASK;

  always_comb begin
    walk_next = walk;
    fire      = 1'b0;
    result    = '0;

    if (item.action == ACTION_START) begin
      fire                  = 1'b1;
      walk_next.page_number = item.vaddr[PAGE_SHIFT +: VPN_W];
      walk_next.level       = 2'd0;
      if (root == '0) begin
        walk_next.table_base = '0;
        walk_next.busy       = 1'b0;
        result.result_kind   = KIND_DONE;
        result.status        = STATUS_NO_ROOT;
      end else begin
        walk_next.table_base = root[ADDR_W-1:PAGE_SHIFT];
        walk_next.busy       = 1'b1;
        result.result_kind   = KIND_READ;
      end
    end else if (walk.busy) begin
      fire = 1'b1;
      if (!item.read_entry[0]) begin
        walk_next.busy     = 1'b0;
        result.result_kind = KIND_DONE;
        result.status      = STATUS_INVALID;
        result.fault_level = walk.level;
      end else if (walk.level != LEVEL_LAST) begin
        walk_next.table_base = entry_pa[ADDR_W-1:PAGE_SHIFT];
        walk_next.level      = walk.level + 2'd1;
        result.result_kind   = KIND_READ;
      end else begin
        walk_next.busy           = 1'b0;
        walk_next.level          = 2'd0;
        result.result_kind       = KIND_DONE;
        result.status            = STATUS_MAPPED;
        result.phys_page         = entry_pa;
        result.leaf_is_table     = item.read_entry[1];
        result.leaf_access_perm  = item.read_entry[7:6];
        result.leaf_shareability = item.read_entry[9:8];
        result.leaf_access_flag  = item.read_entry[10];
        result.leaf_priv_xn      = item.read_entry[53];
        result.leaf_user_xn      = item.read_entry[54];
        result.leaf_attr_index   = item.read_entry[4:2];
      end
    end

    // entry address: table base plus index times 8, from the next state
    case (walk_next.level)
      2'd0:    idx = walk_next.page_number[4*INDEX_BITS-1:3*INDEX_BITS];
      2'd1:    idx = walk_next.page_number[3*INDEX_BITS-1:2*INDEX_BITS];
      2'd2:    idx = walk_next.page_number[2*INDEX_BITS-1:INDEX_BITS];
      default: idx = walk_next.page_number[INDEX_BITS-1:0];
    endcase
    if (result.result_kind == KIND_READ && fire) begin
      result.read_addr = {walk_next.table_base, idx, 3'b000};
    end
  end

endmodule

>>> rtl/four_level_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level table walk, 4 KiB granule: issues entry reads, ends with the
// physical page and leaf attributes, a no-root report or a level fault.
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction  carries
//  -------   ------------------------------------  ---------  -------------------
//  item      item_valid, item_stall, item          in         start / read response
//  result    result_valid, result_stall, result    out        read request / finish
//  cfg       cfg_valid, cfg_ready, cfg_data        in         root_table_base write
//
//  - One transaction per cycle while item_stall is low; a result appears in the cycle after its
//    transaction is taken (one combinational step, one result register).
//  - A read response with no walk in flight causes no result.
//  - item_stall is high only while the result register holds a transaction
//    that result_stall keeps from leaving.
//  - Synchronous active-high rst clears the walk state, root base and
//    result_valid; cfg_ready is always high.
//
module four_level_page_table_walker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [flptw_pkg::ADDR_W-1:0] cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  flptw_pkg::item_t             item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output flptw_pkg::result_t           result
);
  import flptw_pkg::*;

  logic [ADDR_W-1:0] root_table_base;
  walk_state_t       walk;
  walk_state_t       walk_next;
  logic              step_fire;
  result_t           step_result;
  logic              take;

  assign cfg_ready  = 1'b1;
  // Result register frees up in the same cycle it is drained
  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  flptw_step u_step (
    .walk            (walk),
    .item            (item),
    .root_table_base (root_table_base),
    .walk_next       (walk_next),
    .fire            (step_fire),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_table_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (take) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && step_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload only; no reset needed
  always_ff @(posedge clk) begin
    if (take && step_fire) begin
      result <= step_result;
    end
  end

  // A pending read request always belongs to a walk still in flight
  a_read_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == KIND_READ |-> walk.busy)
    else $error("read request pending with no walk in flight");

  // A stray response produces nothing
  a_stray_response: assert property (@(posedge clk) disable iff (rst)
    take && !walk.busy && item.action == ACTION_RESPONSE |=> !result_valid)
    else $error("result produced for a response with no walk");

  // Entry reads are 8-byte aligned
  a_read_aligned: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == KIND_READ |-> result.read_addr[2:0] == 3'b000)
    else $error("misaligned entry read");

  // Only an invalid entry reports a nonzero fault level
  a_fault_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_INVALID |-> result.fault_level == 2'd0)
    else $error("fault level set without a fault");

endmodule

>>> bench/walk_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// walk_scoreboard_pkg
// Walk predictor and result scoreboard for the four-level table walker bench.
// ----------------------------------------------------------------------------
package walk_scoreboard_pkg;

  import flptw_pkg::*;

  class walk_scoreboard;

    // predicted walker state, reset values
    logic [ADDR_W-1:0] root_base;
    logic              walking;
    logic [1:0]        level;
    logic [VPN_W-1:0]  page_number;
    logic [BASE_W-1:0] table_base;

    result_t     expected_q[$];
    int unsigned produced;
    int unsigned mismatches;

    function new();
      root_base   = '0;
      walking     = 1'b0;
      level       = '0;
      page_number = '0;
      table_base  = '0;
      produced    = 0;
      mismatches  = 0;
    endfunction

    function void set_root(logic [ADDR_W-1:0] value);
      root_base = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // one accepted transaction in, zero or one expected result out
    function void predict_step(item_t it);
      result_t           r;
      logic [ADDR_W-1:0] root_pa;
      logic [ADDR_W-1:0] entry_pa;
      logic [VPN_W-1:0]  vpn_shifted;
      logic [INDEX_BITS-1:0] idx;
      int                shift;
      bit                emit;

      r        = '0;
      emit     = 1'b1;
      entry_pa = it.read_entry[ADDR_W-1:0] & PA_MASK;

      if (it.action == ACTION_START) begin
        root_pa     = root_base & PA_MASK;
        page_number = it.vaddr[PAGE_SHIFT +: VPN_W];
        level       = '0;
        if (root_pa == '0) begin
          table_base    = '0;
          walking       = 1'b0;
          r.result_kind = KIND_DONE;
          r.status      = STATUS_NO_ROOT;
        end else begin
          table_base = root_pa[ADDR_W-1:PAGE_SHIFT];
          walking    = 1'b1;
        end
      end else if (!walking) begin
        emit = 1'b0;  // stray response, dropped
      end else if (!it.read_entry[0]) begin
        walking       = 1'b0;
        r.result_kind = KIND_DONE;
        r.status      = STATUS_INVALID;
        r.fault_level = level;
      end else if (level != LEVEL_LAST) begin
        table_base = entry_pa[ADDR_W-1:PAGE_SHIFT];
        level      = level + 2'd1;
      end else begin
        walking               = 1'b0;
        level                 = '0;
        r.result_kind         = KIND_DONE;
        r.status              = STATUS_MAPPED;
        r.phys_page           = entry_pa;
        r.leaf_is_table       = it.read_entry[1];
        r.leaf_access_perm    = it.read_entry[7:6];
        r.leaf_shareability   = it.read_entry[9:8];
        r.leaf_access_flag    = it.read_entry[10];
        r.leaf_priv_xn        = it.read_entry[53];
        r.leaf_user_xn        = it.read_entry[54];
        r.leaf_attr_index     = it.read_entry[4:2];
      end

      if (emit && r.result_kind == KIND_READ) begin
        shift       = INDEX_BITS * (int'(LEVEL_LAST) - int'(level));
        vpn_shifted = page_number >> shift;
        idx         = vpn_shifted[INDEX_BITS-1:0];
        r.read_addr = {table_base, {PAGE_SHIFT{1'b0}}} + (ADDR_W'(idx) << 3);
      end

      if (emit) begin
        expected_q.push_back(r);
        produced++;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing expected: %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("read_addr", want.read_addr, got.read_addr);
      compare_field("status", want.status, got.status);
      compare_field("fault_level", want.fault_level, got.fault_level);
      compare_field("phys_page", want.phys_page, got.phys_page);
      compare_field("leaf_is_table", want.leaf_is_table, got.leaf_is_table);
      compare_field("leaf_access_perm", want.leaf_access_perm, got.leaf_access_perm);
      compare_field("leaf_shareability", want.leaf_shareability, got.leaf_shareability);
      compare_field("leaf_access_flag", want.leaf_access_flag, got.leaf_access_flag);
      compare_field("leaf_priv_xn", want.leaf_priv_xn, got.leaf_priv_xn);
      compare_field("leaf_user_xn", want.leaf_user_xn, got.leaf_user_xn);
      compare_field("leaf_attr_index", want.leaf_attr_index, got.leaf_attr_index);
    endfunction

  endclass

endpackage

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level page table walker: directed walks
// over the field extremes and corner cases, then randomized walks over
// several root table settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import flptw_pkg::*;
  import walk_scoreboard_pkg::*;

  localparam int          CLK_PERIOD  = 4;
  localparam int          RST_CYCLES  = 9;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int unsigned SETTLE      = 4;     // margin past the walker result register
  localparam int unsigned STUCK_LIMIT = 3000;  // cycles with no transaction

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data     = '0;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  item_t             item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;

  // idle rates; dropped to zero for the quiet stretch
  int unsigned src_idle_pct  = IDLE_PCT;
  int unsigned sink_stall_pct = IDLE_PCT;
  bit          hold_req      = 1'b0;

  walk_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  four_level_page_table_walker_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. The result check runs
  // before the new transaction is predicted; a result always belongs to an
  // older transaction, so the order only matters for readability.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(result);
    if (!rst && item_valid && !item_stall)
      sb.predict_step(item);
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stall per cycle, or a counted hold-off on request
  // so the result register fills and the walker pushes back on its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no transaction moves on any channel for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("[%0t] watchdog: no progress for %0d cycles", $time, STUCK_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks. All of them are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one transaction; random idle cycles first. Valid stays up and the
  // payload stays put until the walker takes it.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // the unused field carries noise, the walker must ignore it
  task automatic send_start(input logic [63:0] va);
    item_t it;
    it.action     = ACTION_START;
    it.vaddr      = va;
    it.read_entry = rand64();
    send_item(it);
  endtask

  task automatic send_entry(input logic [63:0] entry);
    item_t it;
    it.action     = ACTION_RESPONSE;
    it.vaddr      = rand64();
    it.read_entry = entry;
    send_item(it);
  endtask

  // Sender stops and waits until every predicted result is back, then a few
  // more cycles in case a dropped response is still in the pipe.
  task automatic drain_walks();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_root(input logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_root(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random walk. Mostly full walks down to a leaf, the rest faults at a
  // random level, abandoned walks (next start restarts) and stray responses.
  task automatic random_walk();
    int unsigned pick;
    int unsigned depth;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_entry(rand64());
      return;
    end
    send_start(rand64());
    depth = (pick < 60) ? 4 : $urandom_range(3);
    for (int i = 0; i < depth; i++)
      send_entry(rand64() | 64'h1);
    if (depth < 4) begin
      if ($urandom_range(9) == 0)
        return;
      send_entry(rand64() & ~64'h1);
    end
  endtask

  // one root setting: drain, program, then walks until enough results
  task automatic run_phase(input logic [ADDR_W-1:0] root, input int unsigned n_results,
                           input bit hold_off);
    int unsigned target;
    drain_walks();
    write_root(root);
    if (hold_off)
      hold_req = 1'b1;
    target = sb.produced + n_results;
    while (sb.produced < target)
      random_walk();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // -- directed --
    // root still at its reset value of zero: no-root finish
    send_start(64'hFFFF_FFFF_FFFF_FFFF);
    // only offset bits set in the root never count as a table
    drain_walks();
    write_root(48'h0000_0000_0FFF);
    send_start(rand64());
    // response with no walk running is dropped
    send_entry(rand64() | 64'h1);

    drain_walks();
    write_root(48'hFFFF_FFFF_FFFF);
    // all-ones walk: top indexes, top bases, every leaf attribute set
    send_start(64'hFFFF_FFFF_FFFF_FFFF);
    repeat (4) send_entry(64'hFFFF_FFFF_FFFF_FFFF);
    // all-zero walk: index zero everywhere, table base zero, bare leaf
    send_start(64'h0);
    repeat (4) send_entry(64'h1);
    // start while busy abandons the old walk; fault at level 0 with
    // everything but the valid bit set
    send_start(64'h0000_5555_5555_5000);
    send_entry(64'h1);
    send_start(64'h0000_AAAA_AAAA_A000);
    send_entry(64'hFFFF_FFFF_FFFF_FFFE);
    // fault on the last level
    send_start(rand64());
    repeat (3) send_entry(rand64() | 64'h1);
    send_entry(64'h0);

    // -- random --
    run_phase(ADDR_W'(rand64()), 80, 1'b0);
    run_phase(48'h0, 10, 1'b0);                  // no root at all
    run_phase(48'h0000_0000_1000, 80, 1'b0);     // lowest real root
    src_idle_pct   = 0;                          // quiet stretch, both sides
    sink_stall_pct = 0;
    run_phase(ADDR_W'(rand64()), 80, 1'b0);
    src_idle_pct   = IDLE_PCT;
    sink_stall_pct = IDLE_PCT;
    run_phase(48'hFFFF_FFFF_FFFF, 80, 1'b1);     // top root, receiver hold-off
    run_phase(ADDR_W'(rand64()), 80, 1'b0);

    drain_walks();
    repeat (8) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> four_level_page_table_walker_top.f
rtl/flptw_pkg.sv
rtl/flptw_step.sv
rtl/four_level_page_table_walker_top.sv
bench/walk_scoreboard_pkg.sv
bench/tb_top.sv
